/* sv/kv_tbl_pkg.sv */
package kv_tbl_pkg;

    // default sizes
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    // fixed widths of the request and result fields
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_ASSIGN = 2'd0;
    localparam cmd_t CMD_ERASE  = 2'd1;
    localparam cmd_t CMD_LOOKUP = 2'd2;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_MISSING = 2'd1;
    localparam status_t STATUS_FULL    = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic do_match;
        logic do_update;
    } ctl_cmd_t;

endpackage

/* sv/kv_tbl_ctrl.sv */
module kv_tbl_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output kv_tbl_pkg::ctl_cmd_t cmd
);
    import kv_tbl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MATCH  = 3'b010,
        S_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   update_ok;
    logic   accept;

    // the result register can take a new result this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign update_ok = (state_reg == S_UPDATE) && out_free;

    // a new request is taken while idle or while the previous one retires
    assign in_stall = !((state_reg == S_IDLE) || update_ok);
    assign accept   = in_valid && !in_stall;

    assign cmd.load_req  = accept;
    assign cmd.do_match  = (state_reg == S_MATCH);
    assign cmd.do_update = update_ok;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (update_ok)
                begin
                    state_next = accept ? S_MATCH : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (update_ok)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a result is only produced after a request has been matched
    a_update_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_update |-> $past(state_reg) == S_MATCH || $past(state_reg) == S_UPDATE)
        else $error("update without a preceding match");

    // a new result never lands on a stalled one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.do_update)
        else $error("result overwritten while stalled");

    // a request is never taken while one is being matched
    a_no_accept_in_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MATCH) |-> !cmd.load_req)
        else $error("request taken during match");

endmodule

/* sv/kv_tbl_dp.sv */
module kv_tbl_dp
#(
    parameter int ENTRIES    = kv_tbl_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = kv_tbl_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = kv_tbl_pkg::DEF_VALUE_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  kv_tbl_pkg::ctl_cmd_t             cmd,
    input  logic [kv_tbl_pkg::CMD_W-1:0]     command,
    input  logic [kv_tbl_pkg::KEY_W-1:0]     key,
    input  logic [kv_tbl_pkg::VALUE_W-1:0]   value,
    output logic                             found,
    output logic [kv_tbl_pkg::VALUE_W-1:0]   read_value,
    output logic [kv_tbl_pkg::COUNT_W-1:0]   entry_count,
    output logic [kv_tbl_pkg::STATUS_W-1:0]  status
);
    import kv_tbl_pkg::*;

    // keys and values only use the low bits of the 32-bit fields
    localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int VW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // request registers
    cmd_t            req_cmd_reg;
    logic [KW-1:0]   req_key_reg;
    logic [VW-1:0]   req_val_reg;

    // table state
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [KW-1:0]      key_reg [ENTRIES];
    logic [VW-1:0]      value_mem [ENTRIES];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // match results
    logic               hit_next;
    logic [IDX_W-1:0]   hit_idx_next;
    logic               free_ok_next;
    logic [IDX_W-1:0]   free_idx_next;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               free_ok_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    // update decode
    logic               do_insert;
    logic               do_write;
    logic               do_erase;
    logic [IDX_W-1:0]   wr_idx;
    status_t            status_next;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    // result registers
    logic               out_found_reg;
    logic               out_rd_en_reg;
    logic [VW-1:0]      rd_data_reg;
    logic [COUNT_W-1:0] out_count_reg;
    status_t            out_status_reg;

    // parallel compare, lowest matching and lowest free entry win
    always_comb
    begin
        hit_next      = 1'b0;
        hit_idx_next  = '0;
        free_ok_next  = 1'b0;
        free_idx_next = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_reg[i] && (key_reg[i] == req_key_reg) && !hit_next)
            begin
                hit_next     = 1'b1;
                hit_idx_next = IDX_W'(i);
            end
            if (!valid_reg[i] && !free_ok_next)
            begin
                free_ok_next  = 1'b1;
                free_idx_next = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        do_insert   = 1'b0;
        do_write    = 1'b0;
        do_erase    = 1'b0;
        status_next = STATUS_OK;
        case (req_cmd_reg)
            CMD_ASSIGN:
            begin
                do_write  = hit_reg || free_ok_reg;
                do_insert = !hit_reg && free_ok_reg;
                if (!hit_reg && !free_ok_reg)
                begin
                    status_next = STATUS_FULL;
                end
            end
            CMD_ERASE:
            begin
                do_erase = hit_reg;
            end
            CMD_LOOKUP:
            begin
                if (!hit_reg)
                begin
                    status_next = STATUS_MISSING;
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    assign wr_idx = hit_reg ? hit_idx_reg : free_idx_reg;

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (do_insert)
        begin
            valid_next[free_idx_reg] = 1'b1;
            count_next               = count_reg + CNT_W'(1);
        end
        else if (do_erase)
        begin
            valid_next[hit_idx_reg] = 1'b0;
            count_next              = count_reg - CNT_W'(1);
        end
    end

    assign count_ext = (CNT_W + COUNT_W)'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.do_update)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_cmd_reg <= command;
            req_key_reg <= key[KW-1:0];
            req_val_reg <= value[VW-1:0];
        end
        if (cmd.do_match)
        begin
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            free_ok_reg  <= free_ok_next;
            free_idx_reg <= free_idx_next;
        end
        if (cmd.do_update)
        begin
            if (do_insert)
            begin
                key_reg[free_idx_reg] <= req_key_reg;
            end
            out_found_reg  <= hit_reg;
            out_rd_en_reg  <= (req_cmd_reg == CMD_LOOKUP) && hit_reg;
            out_count_reg  <= count_ext[COUNT_W-1:0];
            out_status_reg <= status_next;
        end
    end

    // value store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.do_update)
        begin
            if (do_write)
            begin
                value_mem[wr_idx] <= req_val_reg;
            end
            rd_data_reg <= value_mem[hit_idx_reg];
        end
    end

    assign found       = out_found_reg;
    assign read_value  = out_rd_en_reg ? VALUE_W'(rd_data_reg) : '0;
    assign entry_count = out_count_reg;
    assign status      = out_status_reg;

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(count_reg))
        else $error("entry count differs from valid entries");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= ENTRIES)
        else $error("entry count above capacity");

    // the matched entry stays valid until the update uses it
    a_hit_still_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_update && hit_reg) |-> valid_reg[hit_idx_reg])
        else $error("hit entry invalid at update");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_update && status_next == STATUS_FULL) |-> (&valid_reg))
        else $error("table full reported with a free entry");

endmodule

/* sv/key_value_table_top.sv */
// a request is taken into the request registers, matched (parallel key compare into a
//   registered hit index) and then updated into the result registers; a new request
//   can be taken during that update unless a stalled result holds the update back
// a new request is taken while a finished result waits to be taken
// reset: asynchronous, active low; clears all entry valid bits, the entry
//   count and the handshake state; keys and values are not cleared
module key_value_table_top
#(
    parameter int ENTRIES    = kv_tbl_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = kv_tbl_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = kv_tbl_pkg::DEF_VALUE_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [kv_tbl_pkg::CMD_W-1:0]     command,
    input  logic [kv_tbl_pkg::KEY_W-1:0]     key,
    input  logic [kv_tbl_pkg::VALUE_W-1:0]   value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             found,
    output logic [kv_tbl_pkg::VALUE_W-1:0]   read_value,
    output logic [kv_tbl_pkg::COUNT_W-1:0]   entry_count,
    output logic [kv_tbl_pkg::STATUS_W-1:0]  status
);
    import kv_tbl_pkg::*;

    ctl_cmd_t ctl_cmd;

    kv_tbl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (ctl_cmd)
    );

    kv_tbl_dp
    #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctl_cmd),
        .command     (command),
        .key         (key),
        .value       (value),
        .found       (found),
        .read_value  (read_value),
        .entry_count (entry_count),
        .status      (status)
    );

endmodule
